FILE: rtl/bairs_pkg.sv
// Shared types and constants for the bounded array core.
// No dependencies; every other file but bairs_ram imports this package.
package bairs_pkg;

    localparam int DEPTH   = 64;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int ACT_W   = 3;
    localparam int IDX_W   = 7;
    localparam int VAL_W   = 32;
    localparam int ST_W    = 2;
    localparam int POS_W   = 6;
    localparam int CNT_W   = 7;
    localparam int APB_AW  = 2;
    localparam int APB_DW  = 32;

    typedef enum logic [ACT_W-1:0] {
        ACT_GET    = 3'd0,
        ACT_SET    = 3'd1,
        ACT_APPEND = 3'd2,
        ACT_INSERT = 3'd3,
        ACT_REMOVE = 3'd4,
        ACT_FIND   = 3'd5
    } t_action;

    typedef enum logic [ST_W-1:0] {
        ST_OK        = 2'd0,
        ST_BAD_INDEX = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        PTR_IDX     = 2'd0,
        PTR_ZERO    = 2'd1,
        PTR_FILL_M1 = 2'd2
    } t_ptr_src;

    // controller -> datapath
    typedef struct packed {
        logic     req_load;
        logic     ptr_load;
        t_ptr_src ptr_src;
        logic     ptr_inc;
        logic     ptr_dec;
        logic     rd_issue;
        logic     shift_wr;
        logic     val_wr;
        logic     data_cap;
        logic     pos_cap;
        logic     moved_set;
        logic     st_set;
        t_status  st_code;
        logic     fill_inc;
        logic     fill_dec;
        logic     out_load;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        t_action act;
        logic    full;
        logic    idx_lt_fill;
        logic    idx_le_fill;
        logic    idx_eq_fill;
        logic    fill_zero;
        logic    ptr_lt_fill;
        logic    shift_last;
        logic    match;
        logic    cmp_last;
        logic    out_busy;
    } t_sts;

endpackage

FILE: rtl/bairs_req_if.sv
// Request channel: valid/ready handshake with the request fields.
// Depends on bairs_pkg for field widths.
interface bairs_req_if import bairs_pkg::*; ;
    logic                    valid;
    logic                    ready;
    logic [ACT_W-1:0]        action;
    logic [IDX_W-1:0]        index;
    logic signed [VAL_W-1:0] value;

    modport source(output valid, action, index, value, input ready);
    modport sink(input valid, action, index, value, output ready);
endinterface

FILE: rtl/bairs_rsp_if.sv
// Response channel: valid/ready handshake with the result fields.
// Depends on bairs_pkg for field widths.
interface bairs_rsp_if import bairs_pkg::*; ;
    logic                    valid;
    logic                    ready;
    logic [ST_W-1:0]         status;
    logic signed [VAL_W-1:0] data_out;
    logic [POS_W-1:0]        position;
    logic [CNT_W-1:0]        moved_count;
    logic [CNT_W-1:0]        element_count;

    modport source(output valid, status, data_out, position, moved_count, element_count,
                   input ready);
    modport sink(input valid, status, data_out, position, moved_count, element_count,
                 output ready);
endinterface

FILE: rtl/bounded_array_insert_remove_search_core.sv
// Bounded array core: a dense array of up to min(capacity, 64) signed 32-bit
// words with get, set, append, insert, remove and find. One transaction is
// worked at a time; the response sits in an output register, so the next
// request is taken while it waits. Insert and remove shift the words behind
// the index one by one, and find walks from the front until it hits a match
// or the last word. The walks run at one word per cycle, set by the store's
// single read and single write port; a response still held at the output
// holds back the response of the next request.
// Writing the capacity register (APB, offset 0) empties the array; the store
// itself is not cleared.
// Depends on bairs_pkg, bairs_req_if, bairs_rsp_if, bairs_ctrl and bairs_dp.
module bounded_array_insert_remove_search_core import bairs_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    bairs_req_if.sink         i_req,
    bairs_rsp_if.source       o_rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    t_cmd cmd;
    t_sts sts;
    logic req_ready;

    assign pready      = 1'b1;
    assign i_req.ready = req_ready;

    bairs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (req_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    bairs_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_action        (i_req.action),
        .i_index         (i_req.index),
        .i_value         (i_req.value),
        .i_out_ready     (o_rsp.ready),
        .o_out_valid     (o_rsp.valid),
        .o_status        (o_rsp.status),
        .o_data_out      (o_rsp.data_out),
        .o_position      (o_rsp.position),
        .o_moved_count   (o_rsp.moved_count),
        .o_element_count (o_rsp.element_count),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata)
    );

endmodule

FILE: rtl/bairs_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module bairs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/bairs_dp.sv
// Datapath: element store, fill count, capacity register, walk pointer and
// result registers. Depends on bairs_pkg and bairs_ram.
module bairs_dp import bairs_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cmd                    i_cmd,
    output t_sts                    o_sts,
    input  logic [ACT_W-1:0]        i_action,
    input  logic [IDX_W-1:0]        i_index,
    input  logic signed [VAL_W-1:0] i_value,
    input  logic                    i_out_ready,
    output logic                    o_out_valid,
    output logic [ST_W-1:0]         o_status,
    output logic signed [VAL_W-1:0] o_data_out,
    output logic [POS_W-1:0]        o_position,
    output logic [CNT_W-1:0]        o_moved_count,
    output logic [CNT_W-1:0]        o_element_count,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [APB_AW-1:0]       paddr,
    input  logic [APB_DW-1:0]       pwdata,
    output logic [APB_DW-1:0]       prdata
);

    logic [CNT_W-1:0]        r_cap;
    logic [CNT_W-1:0]        r_fill;
    t_action                 r_act;
    logic [IDX_W-1:0]        r_idx;
    logic [VAL_W-1:0]        r_val;
    logic [CNT_W-1:0]        r_ptr;
    logic                    r_rd_pend;
    logic [CNT_W-1:0]        r_rd_addr;
    t_status                 r_status;
    logic [VAL_W-1:0]        r_data;
    logic [POS_W-1:0]        r_pos;
    logic [CNT_W-1:0]        r_moved;
    logic                    r_out_valid;
    logic [ST_W-1:0]         r_out_status;
    logic [VAL_W-1:0]        r_out_data;
    logic [POS_W-1:0]        r_out_pos;
    logic [CNT_W-1:0]        r_out_moved;
    logic [CNT_W-1:0]        r_out_count;

    logic                    cfg_wr;
    logic [CNT_W-1:0]        eff_cap;
    logic [CNT_W-1:0]        fill_m1;
    logic                    wr_en;
    logic [ADDR_W-1:0]       wr_addr;
    logic [VAL_W-1:0]        wr_data;
    logic [VAL_W-1:0]        rd_data;
    logic [CNT_W-1:0]        n_ptr;

    // capacity is the only register, at offset zero
    assign cfg_wr  = psel && penable && pwrite && (paddr == '0);
    assign prdata  = {{(APB_DW-CNT_W){1'b0}}, r_cap};
    assign eff_cap = (r_cap > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : r_cap;
    assign fill_m1 = r_fill - CNT_W'(1);

    // a pending read is a shifted word when the controller asks for it
    assign wr_en   = (i_cmd.shift_wr && r_rd_pend) || i_cmd.val_wr;
    always_comb begin
        if (i_cmd.shift_wr && r_rd_pend) begin
            wr_data = rd_data;
            if (r_act == ACT_REMOVE) begin
                wr_addr = ADDR_W'(r_rd_addr - CNT_W'(1));
            end else begin
                wr_addr = ADDR_W'(r_rd_addr + CNT_W'(1));
            end
        end else begin
            wr_data = r_val;
            wr_addr = r_idx[ADDR_W-1:0];
        end
    end

    bairs_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_raddr (r_ptr[ADDR_W-1:0]),
        .o_rdata (rd_data)
    );

    always_comb begin
        n_ptr = r_ptr;
        if (i_cmd.ptr_load) begin
            case (i_cmd.ptr_src)
                PTR_IDX:     n_ptr = r_idx;
                PTR_ZERO:    n_ptr = '0;
                PTR_FILL_M1: n_ptr = fill_m1;
                default:     n_ptr = r_idx;
            endcase
        end else if (i_cmd.ptr_inc) begin
            n_ptr = r_ptr + CNT_W'(1);
        end else if (i_cmd.ptr_dec) begin
            n_ptr = r_ptr - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= CNT_W'(DEPTH);
            r_fill      <= '0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_wr) begin
                r_cap  <= pwdata[CNT_W-1:0];
                r_fill <= '0;
            end else if (i_cmd.fill_inc) begin
                r_fill <= r_fill + CNT_W'(1);
            end else if (i_cmd.fill_dec) begin
                r_fill <= r_fill - CNT_W'(1);
            end
            r_rd_pend <= i_cmd.rd_issue;
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr     <= n_ptr;
        r_rd_addr <= r_ptr;
        if (i_cmd.req_load) begin
            r_act    <= t_action'(i_action);
            // append is an insert at the current end
            r_idx    <= (t_action'(i_action) == ACT_APPEND) ? r_fill : i_index;
            r_val    <= i_value;
            r_status <= ST_OK;
            r_data   <= '0;
            r_pos    <= '0;
            r_moved  <= '0;
        end else begin
            if (i_cmd.st_set) begin
                r_status <= i_cmd.st_code;
            end
            if (i_cmd.data_cap) begin
                r_data <= rd_data;
            end
            if (i_cmd.pos_cap) begin
                r_pos <= r_rd_addr[POS_W-1:0];
            end
            if (i_cmd.moved_set) begin
                if (r_act == ACT_REMOVE) begin
                    r_moved <= r_fill - r_idx - CNT_W'(1);
                end else begin
                    r_moved <= r_fill - r_idx;
                end
            end
        end
        if (i_cmd.out_load) begin
            r_out_status <= r_status;
            r_out_data   <= r_data;
            r_out_pos    <= r_pos;
            r_out_moved  <= r_moved;
            r_out_count  <= r_fill;
        end
    end

    always_comb begin
        o_sts.act         = r_act;
        o_sts.full        = (r_fill >= eff_cap);
        o_sts.idx_lt_fill = (r_idx < r_fill);
        o_sts.idx_le_fill = (r_idx <= r_fill);
        o_sts.idx_eq_fill = (r_idx == r_fill);
        o_sts.fill_zero   = (r_fill == '0);
        o_sts.ptr_lt_fill = (r_ptr < r_fill);
        o_sts.shift_last  = (r_act == ACT_REMOVE) ? (r_ptr == fill_m1) : (r_ptr == r_idx);
        o_sts.match       = r_rd_pend && (rd_data == r_val);
        o_sts.cmp_last    = r_rd_pend && (r_rd_addr == fill_m1);
        o_sts.out_busy    = r_out_valid && !i_out_ready;
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_data_out      = r_out_data;
    assign o_position      = r_out_pos;
    assign o_moved_count   = r_out_moved;
    assign o_element_count = r_out_count;

endmodule

FILE: rtl/bairs_ctrl.sv
// Controller: one-hot state machine sequencing each request over the datapath.
// Depends on bairs_pkg.
module bairs_ctrl import bairs_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_DECODE = 9'b000000010,
        S_RD     = 9'b000000100,
        S_CAP    = 9'b000001000,
        S_SHIFT  = 9'b000010000,
        S_DRAIN  = 9'b000100000,
        S_TAIL   = 9'b001000000,
        S_FIND   = 9'b010000000,
        S_FINISH = 9'b100000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_req_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.req_load = 1'b1;
                    n_state        = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_FINISH;
                case (i_sts.act)
                    ACT_GET: begin
                        if (i_sts.idx_lt_fill) begin
                            o_cmd.ptr_load = 1'b1;
                            o_cmd.ptr_src  = PTR_IDX;
                            n_state        = S_RD;
                        end else begin
                            o_cmd.st_set  = 1'b1;
                            o_cmd.st_code = ST_BAD_INDEX;
                        end
                    end
                    ACT_SET: begin
                        if (i_sts.idx_lt_fill) begin
                            o_cmd.val_wr = 1'b1;
                        end else begin
                            o_cmd.st_set  = 1'b1;
                            o_cmd.st_code = ST_BAD_INDEX;
                        end
                    end
                    ACT_APPEND, ACT_INSERT: begin
                        // full is reported ahead of a bad index
                        if (i_sts.full) begin
                            o_cmd.st_set  = 1'b1;
                            o_cmd.st_code = ST_FULL;
                        end else if (!i_sts.idx_le_fill) begin
                            o_cmd.st_set  = 1'b1;
                            o_cmd.st_code = ST_BAD_INDEX;
                        end else begin
                            o_cmd.moved_set = 1'b1;
                            if (i_sts.idx_eq_fill) begin
                                n_state = S_TAIL;
                            end else begin
                                o_cmd.ptr_load = 1'b1;
                                o_cmd.ptr_src  = PTR_FILL_M1;
                                n_state        = S_SHIFT;
                            end
                        end
                    end
                    ACT_REMOVE: begin
                        if (i_sts.idx_lt_fill) begin
                            o_cmd.moved_set = 1'b1;
                            o_cmd.ptr_load  = 1'b1;
                            o_cmd.ptr_src   = PTR_IDX;
                            n_state         = S_RD;
                        end else begin
                            o_cmd.st_set  = 1'b1;
                            o_cmd.st_code = ST_BAD_INDEX;
                        end
                    end
                    ACT_FIND: begin
                        if (i_sts.fill_zero) begin
                            o_cmd.st_set  = 1'b1;
                            o_cmd.st_code = ST_NOT_FOUND;
                        end else begin
                            o_cmd.ptr_load = 1'b1;
                            o_cmd.ptr_src  = PTR_ZERO;
                            n_state        = S_FIND;
                        end
                    end
                    default: begin
                        n_state = S_FINISH;
                    end
                endcase
            end
            S_RD: begin
                o_cmd.rd_issue = 1'b1;
                o_cmd.ptr_inc  = 1'b1;
                n_state        = S_CAP;
            end
            S_CAP: begin
                o_cmd.data_cap = 1'b1;
                if (i_sts.act == ACT_REMOVE) begin
                    n_state = i_sts.ptr_lt_fill ? S_SHIFT : S_TAIL;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_SHIFT: begin
                // read one word, write back the one read last cycle
                o_cmd.shift_wr = 1'b1;
                o_cmd.rd_issue = 1'b1;
                if (i_sts.shift_last) begin
                    n_state = S_DRAIN;
                end else if (i_sts.act == ACT_REMOVE) begin
                    o_cmd.ptr_inc = 1'b1;
                end else begin
                    o_cmd.ptr_dec = 1'b1;
                end
            end
            S_DRAIN: begin
                o_cmd.shift_wr = 1'b1;
                n_state        = S_TAIL;
            end
            S_TAIL: begin
                if (i_sts.act == ACT_REMOVE) begin
                    o_cmd.fill_dec = 1'b1;
                end else begin
                    o_cmd.val_wr   = 1'b1;
                    o_cmd.fill_inc = 1'b1;
                end
                n_state = S_FINISH;
            end
            S_FIND: begin
                if (i_sts.match) begin
                    o_cmd.pos_cap = 1'b1;
                    n_state       = S_FINISH;
                end else if (i_sts.cmp_last) begin
                    o_cmd.st_set  = 1'b1;
                    o_cmd.st_code = ST_NOT_FOUND;
                    n_state       = S_FINISH;
                end else if (i_sts.ptr_lt_fill) begin
                    o_cmd.rd_issue = 1'b1;
                    o_cmd.ptr_inc  = 1'b1;
                end
            end
            S_FINISH: begin
                if (!i_sts.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
